@@ rtl/gsh_pkg.sv @@
`default_nettype none

package gsh_pkg;

    localparam int STATE_WORDS = 12;
    localparam int STATE_BYTES = 48;
    localparam int BYTE_POS_W  = 6;
    localparam int NUM_ROUNDS  = 24;
    localparam int ROUND_W     = 5;
    localparam int MAX_DIGEST  = 64;
    localparam int DIG_W       = 7;

    localparam logic [31:0] ROUND_CONST = 32'h9E37_7900;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef logic [31:0] word_t;
    typedef logic [STATE_WORDS-1:0][31:0] state_t;
    typedef logic [ROUND_W-1:0] round_t;

endpackage

`default_nettype wire

@@ rtl/gsh_round.sv @@
`default_nettype none

module gsh_round
    import gsh_pkg::*;
(
    input  state_t s_in,
    input  round_t rnd,
    output state_t s_out
);

    state_t sp;

    // column sp-box
    always_comb
    begin
        word_t x;
        word_t y;
        word_t z;
        sp = s_in;
        for (int c = 0; c < 4; c++)
        begin
            x = {s_in[c][7:0], s_in[c][31:8]};
            y = {s_in[4+c][22:0], s_in[4+c][31:23]};
            z = s_in[8+c];
            sp[8+c] = x ^ (z << 1) ^ ((y & z) << 2);
            sp[4+c] = y ^ x ^ ((x | z) << 1);
            sp[c]   = z ^ y ^ ((x & y) << 3);
        end
    end

    // linear layer and round constant
    always_comb
    begin
        s_out = sp;
        case (rnd[1:0])
            2'b00:
            begin
                s_out[0] = sp[1] ^ ROUND_CONST ^ {{(32-ROUND_W){1'b0}}, rnd};
                s_out[1] = sp[0];
                s_out[2] = sp[3];
                s_out[3] = sp[2];
            end
            2'b10:
            begin
                s_out[0] = sp[2];
                s_out[2] = sp[0];
                s_out[1] = sp[3];
                s_out[3] = sp[1];
            end
            default:
            begin
                s_out = sp;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/gimli_sponge_hash_top.sv @@
// channel   dir  signals                          contents (low bit up)
// s_*       in   s_tvalid s_tready s_tdata s_tuser  tdata: data_byte[7:0]; tuser: op
// m_*       out  m_tvalid m_tready m_tdata m_tlast  tdata: digest_byte[7:0]; tlast: last
// cfg_*     in   cfg_wr_en cfg_wr_data              digest_len[6:0]
//
// absorb xors each item into the state; every RATE_BYTES-th byte starts a
// permutation, one gimli round per cycle through the shared round unit.
// finish pads and permutes the state, then squeezes digest bytes with a new
// permutation per RATE_BYTES bytes; a zero length clears state and offset only.
// s_tready is low while a permutation or squeeze is in progress.
// the output register stalls the squeeze while it is full and m_tready is low.
// rst_n clears the state, the offset and the output; digest_len returns to 32.
`default_nettype none

module gimli_sponge_hash_top
    import gsh_pkg::*;
#(
    parameter int RATE_BYTES = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output      logic             s_tready,
    input  wire logic [7:0]       s_tdata,     // data_byte[7:0]
    input  wire logic             s_tuser,     // op
    output      logic             m_tvalid,
    input  wire logic             m_tready,
    output      logic [7:0]       m_tdata,     // digest_byte[7:0]
    output      logic             m_tlast,
    input  wire logic             cfg_wr_en,
    input  wire logic [DIG_W-1:0] cfg_wr_data
);

    localparam int OFF_W = (RATE_BYTES > 1) ? $clog2(RATE_BYTES) : 1;
    localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(RATE_BYTES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PERM,
        S_SQZ
    } fsm_t;

    fsm_t             fsm_reg, fsm_next;
    state_t           perm_reg, perm_next;
    logic [OFF_W-1:0] off_reg, off_next;
    round_t           round_reg, round_next;
    logic [DIG_W-1:0] remain_reg, remain_next;
    logic             sqz_reg, sqz_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;
    logic [DIG_W-1:0] digest_len_reg;

    state_t                round_out;
    logic [DIG_W-1:0]      dig_n;
    logic [BYTE_POS_W-1:0] off_pos;
    logic [383:0]          perm_flat;

    function automatic state_t byte_mask(input logic [BYTE_POS_W-1:0] pos,
                                         input logic [7:0] val);
        logic [383:0] m;
        m = '0;
        m[{pos, 3'b000} +: 8] = val;
        return state_t'(m);
    endfunction

    gsh_round u_round
    (
        .s_in  (perm_reg),
        .rnd   (round_reg),
        .s_out (round_out)
    );

    assign dig_n     = (digest_len_reg > DIG_W'(MAX_DIGEST)) ? DIG_W'(MAX_DIGEST)
                                                             : digest_len_reg;
    assign off_pos   = BYTE_POS_W'(off_reg);
    assign perm_flat = perm_reg;

    assign s_tready = (fsm_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        fsm_next       = fsm_reg;
        perm_next      = perm_reg;
        off_next       = off_reg;
        round_next     = round_reg;
        remain_next    = remain_reg;
        sqz_next       = sqz_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        case (fsm_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == OP_ABSORB)
                    begin
                        perm_next = perm_reg ^ byte_mask(off_pos, s_tdata);
                        if (off_reg == OFF_LAST)
                        begin
                            off_next   = '0;
                            round_next = round_t'(NUM_ROUNDS);
                            sqz_next   = 1'b0;
                            fsm_next   = S_PERM;
                        end
                        else
                        begin
                            off_next = off_reg + 1'b1;
                        end
                    end
                    else if (dig_n == '0)
                    begin
                        perm_next = '0;
                        off_next  = '0;
                    end
                    else
                    begin
                        perm_next   = perm_reg ^ byte_mask(off_pos, 8'h01)
                                    ^ byte_mask(BYTE_POS_W'(STATE_BYTES - 1), 8'h01);
                        off_next    = '0;
                        remain_next = dig_n;
                        round_next  = round_t'(NUM_ROUNDS);
                        sqz_next    = 1'b1;
                        fsm_next    = S_PERM;
                    end
                end
            end
            S_PERM:
            begin
                perm_next  = round_out;
                round_next = round_reg - 1'b1;
                if (round_reg == round_t'(1))
                begin
                    fsm_next = sqz_reg ? S_SQZ : S_IDLE;
                end
            end
            S_SQZ:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = perm_flat[{off_pos, 3'b000} +: 8];
                    out_last_next  = (remain_reg == DIG_W'(1));
                    remain_next    = remain_reg - 1'b1;
                    if (remain_reg == DIG_W'(1))
                    begin
                        perm_next = '0;
                        off_next  = '0;
                        sqz_next  = 1'b0;
                        fsm_next  = S_IDLE;
                    end
                    else if (off_reg == OFF_LAST)
                    begin
                        off_next   = '0;
                        round_next = round_t'(NUM_ROUNDS);
                        fsm_next   = S_PERM;
                    end
                    else
                    begin
                        off_next = off_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                fsm_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg        <= S_IDLE;
            perm_reg       <= '0;
            off_reg        <= '0;
            round_reg      <= '0;
            remain_reg     <= '0;
            sqz_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_byte_reg   <= '0;
            out_last_reg   <= 1'b0;
            digest_len_reg <= DIG_W'(32);
        end
        else
        begin
            fsm_reg       <= fsm_next;
            perm_reg      <= perm_next;
            off_reg       <= off_next;
            round_reg     <= round_next;
            remain_reg    <= remain_next;
            sqz_reg       <= sqz_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            out_last_reg  <= out_last_next;
            if (cfg_wr_en)
            begin
                digest_len_reg <= cfg_wr_data;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/gsh_checker.sv @@
`default_nettype none

module gsh_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    // stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    // busy only after an accepted item
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid))
        else $error("ready dropped without an accepted item");

    // a digest byte that is not the last means the squeeze is still running
    a_sqz_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready during an unfinished digest");

    // after a taken byte that is not the last, either more bytes follow or the block is busy
    a_sqz_continue: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid || !s_tready)
        else $error("input ready before the last digest byte");

endmodule

bind gimli_sponge_hash_top gsh_checker u_gsh_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
